FILE: hw/rtl/snappy_pkg.sv
// Package for the Snappy block decompressor.
// Holds phase codes, window constants and the front-to-back command type.
// No dependencies.
package snappy_pkg;

	localparam int HistDepth = 65536;
	localparam int HistAw    = $clog2(HistDepth);
	localparam int CntW      = HistAw + 1;
	localparam int LenW      = 7;   // copy length 1..64
	localparam int FifoDepth = 4;
	localparam int FifoAw    = $clog2(FifoDepth);

	typedef enum logic [2:0] {
		PH_PREAMBLE = 3'd0,
		PH_TAG      = 3'd1,
		PH_LITLEN   = 3'd2,
		PH_LITDATA  = 3'd3,
		PH_OFF1     = 3'd4,
		PH_OFF2     = 3'd5,
		PH_DRAIN    = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		CMD_LIT  = 2'd0,
		CMD_COPY = 2'd1,
		CMD_ERR  = 2'd2,
		CMD_END  = 2'd3   // silent byte that only closes a stream
	} cmd_op_t;

	// One request from the front (parser) to the back (executor)
	typedef struct packed {
		cmd_op_t            op;
		logic [7:0]         lit;
		logic [LenW-1:0]    len;
		logic [HistAw-1:0]  offset;   // validated, nonzero
		logic               last;
	} cmd_t;

endpackage

FILE: hw/rtl/snappy_front.sv
// Front end: parses preamble and tags, checks offsets, issues requests.
// Depends on snappy_pkg.
module snappy_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_byte,
	input  logic                stream_last,
	output logic                cmd_valid,
	input  logic                cmd_ready,
	output snappy_pkg::cmd_t    cmd
);

	snappy_pkg::phase_t phase_q, phase_d;
	logic [7:0]  tag_q, tag_d;
	logic [32:0] lit_rem_q, lit_rem_d;
	logic [2:0]  xb_left_q, xb_left_d;
	logic [31:0] acc_q, acc_d;
	logic [snappy_pkg::CntW-1:0] prod_q, prod_d;
	logic        emit;
	logic [1:0]  pos;
	logic [2:0]  total;
	logic [16:0] off_w;
	logic [snappy_pkg::LenW-1:0] clen;

	assign in_ready = cmd_ready;
	wire fire = in_valid && in_ready;

	// Produced-count model, used for offset validation
	function automatic logic [snappy_pkg::CntW-1:0] bump(
		input logic [snappy_pkg::CntW-1:0] c, input logic [snappy_pkg::LenW-1:0] n);
		logic [snappy_pkg::CntW:0] s;
		s = {1'b0, c} + {{(snappy_pkg::CntW+1-snappy_pkg::LenW){1'b0}}, n};
		if (s > (snappy_pkg::CntW+1)'(snappy_pkg::HistDepth))
			return snappy_pkg::CntW'(snappy_pkg::HistDepth);
		return s[snappy_pkg::CntW-1:0];
	endfunction

	always_comb begin
		phase_d   = phase_q;
		tag_d     = tag_q;
		lit_rem_d = lit_rem_q;
		xb_left_d = xb_left_q;
		acc_d     = acc_q;
		prod_d    = prod_q;
		emit      = 1'b0;
		cmd       = '0;
		cmd.op    = snappy_pkg::CMD_END;
		cmd.last  = stream_last;
		total     = 3'(tag_q[7:2] - 6'd59);
		pos       = 2'(total - xb_left_q);
		off_w     = '0;
		clen      = '0;
		case (phase_q)
			snappy_pkg::PH_PREAMBLE: begin
				if (!in_byte[7]) phase_d = snappy_pkg::PH_TAG;
			end
			snappy_pkg::PH_TAG: begin
				tag_d = in_byte;
				case (in_byte[1:0])
					2'd0: begin
						if (in_byte[7:2] < 6'd60) begin
							lit_rem_d = 33'(in_byte[7:2]) + 33'd1;
							phase_d   = snappy_pkg::PH_LITDATA;
						end else begin
							xb_left_d = 3'(in_byte[7:2] - 6'd59);
							acc_d     = '0;
							phase_d   = snappy_pkg::PH_LITLEN;
						end
					end
					2'd1: phase_d = snappy_pkg::PH_OFF1;
					2'd2: begin
						xb_left_d = 3'd2;
						acc_d     = '0;
						phase_d   = snappy_pkg::PH_OFF2;
					end
					default: begin
						emit    = 1'b1;
						cmd.op  = snappy_pkg::CMD_ERR;
						phase_d = snappy_pkg::PH_DRAIN;
					end
				endcase
			end
			snappy_pkg::PH_LITLEN: begin
				acc_d     = acc_q | (32'(in_byte) << {pos, 3'b000});
				xb_left_d = xb_left_q - 3'd1;
				if (xb_left_d == 3'd0) begin
					lit_rem_d = 33'(acc_d) + 33'd1;
					phase_d   = snappy_pkg::PH_LITDATA;
				end
			end
			snappy_pkg::PH_LITDATA: begin
				emit      = 1'b1;
				cmd.op    = snappy_pkg::CMD_LIT;
				cmd.lit   = in_byte;
				prod_d    = bump(prod_q, snappy_pkg::LenW'(1));
				lit_rem_d = lit_rem_q - 33'd1;
				if (lit_rem_d == 33'd0) phase_d = snappy_pkg::PH_TAG;
			end
			snappy_pkg::PH_OFF1, snappy_pkg::PH_OFF2: begin
				if (phase_q == snappy_pkg::PH_OFF1) begin
					clen  = snappy_pkg::LenW'(tag_q[4:2]) + snappy_pkg::LenW'(4);
					off_w = {6'd0, tag_q[7:5], in_byte};
				end else begin
					clen  = snappy_pkg::LenW'(tag_q[7:2]) + snappy_pkg::LenW'(1);
					off_w = {1'b0, in_byte, acc_q[7:0]};
				end
				if (phase_q == snappy_pkg::PH_OFF2 && xb_left_q == 3'd2) begin
					acc_d     = 32'(in_byte);
					xb_left_d = 3'd1;
				end else begin
					emit      = 1'b1;
					xb_left_d = '0;
					if (off_w == 17'd0 || off_w > 17'(prod_q)) begin
						cmd.op  = snappy_pkg::CMD_ERR;
						phase_d = snappy_pkg::PH_DRAIN;
					end else begin
						cmd.op     = snappy_pkg::CMD_COPY;
						cmd.len    = clen;
						cmd.offset = snappy_pkg::HistAw'(off_w);
						prod_d     = bump(prod_q, clen);
						phase_d    = snappy_pkg::PH_TAG;
					end
				end
			end
			default: ;
		endcase
		if (stream_last) emit = 1'b1;
	end

	assign cmd_valid = in_valid && emit;

	// Parser state; a final byte returns everything to reset values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= snappy_pkg::PH_PREAMBLE;
			tag_q     <= '0;
			lit_rem_q <= '0;
			xb_left_q <= '0;
			acc_q     <= '0;
			prod_q    <= '0;
		end else if (fire) begin
			if (stream_last) begin
				phase_q   <= snappy_pkg::PH_PREAMBLE;
				tag_q     <= '0;
				lit_rem_q <= '0;
				xb_left_q <= '0;
				acc_q     <= '0;
				prod_q    <= '0;
			end else begin
				phase_q   <= phase_d;
				tag_q     <= tag_d;
				lit_rem_q <= lit_rem_d;
				xb_left_q <= xb_left_d;
				acc_q     <= acc_d;
				prod_q    <= prod_d;
			end
		end
	end

	a_prod_cap: assert property (@(posedge clk) disable iff (!arst_n)
		prod_q <= snappy_pkg::CntW'(snappy_pkg::HistDepth))
		else $error("produced count above window");
	a_copy_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd.op == snappy_pkg::CMD_COPY) |->
		(cmd.len != '0 && cmd.offset != '0))
		else $error("copy request with zero length or offset");
	a_drain_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == snappy_pkg::PH_DRAIN && cmd_valid) |-> cmd.op == snappy_pkg::CMD_END)
		else $error("output after error");

endmodule

FILE: hw/rtl/snappy_fifo.sv
// Short request queue between parser and executor.
// Depends on snappy_pkg.
module snappy_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  snappy_pkg::cmd_t wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output snappy_pkg::cmd_t rd_data
);

	snappy_pkg::cmd_t mem_q [snappy_pkg::FifoDepth];
	logic [snappy_pkg::FifoAw-1:0] wp_q, rp_q;
	logic [snappy_pkg::FifoAw:0]   cnt_q;

	assign wr_ready = cnt_q != (snappy_pkg::FifoAw+1)'(snappy_pkg::FifoDepth);
	assign rd_valid = cnt_q != '0;
	assign rd_data  = mem_q[rp_q];
	wire wr = wr_valid && wr_ready;
	wire rd = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (snappy_pkg::FifoAw+1)'(wr) - (snappy_pkg::FifoAw+1)'(rd);
		end
	end

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (snappy_pkg::FifoAw+1)'(snappy_pkg::FifoDepth))
		else $error("fifo count overflow");
	a_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0 || cnt_q == (snappy_pkg::FifoAw+1)'(snappy_pkg::FifoDepth))
		|-> wp_q == rp_q)
		else $error("fifo pointers disagree with count");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_valid && !rd_ready) |=> rd_valid)
		else $error("fifo lost an entry");

endmodule

FILE: hw/rtl/snappy_back.sv
// Back end: writes literals into the history window and runs copies.
// Depends on snappy_pkg. History memory lives here.
module snappy_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  snappy_pkg::cmd_t cmd,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       data_byte,
	output logic             run_last,
	output logic             error_flag,
	output logic             stream_end
);

	logic [7:0] hist_q [snappy_pkg::HistDepth];
	logic [snappy_pkg::HistAw-1:0] wp_q;
	// copy engine: stage 1 issues a read, stage 2 has data
	logic                          busy_q;
	logic [snappy_pkg::LenW-1:0]   left_q;
	logic [snappy_pkg::HistAw-1:0] rd_ptr_q;
	logic                          last_q;
	logic                          v_s2, fin_s2, end_s2;
	logic [7:0]                    rdat_s2;
	// output register
	logic       ov_q, rl_q, err_q, se_q;
	logic [7:0] db_q;

	assign out_valid  = ov_q;
	assign data_byte  = db_q;
	assign run_last   = rl_q;
	assign error_flag = err_q;
	assign stream_end = se_q;

	wire oslot   = !ov_q || out_ready;
	wire nxt_emits = v_s2; // copy data takes priority on the out register
	// stage 1 read issue: only when s2 can drain
	wire s2_free = !v_s2 || oslot;
	wire rd_go   = busy_q && s2_free;
	assign cmd_ready = !busy_q && !v_s2 && oslot;
	wire take = cmd_valid && cmd_ready;
	wire wr_lit  = take && cmd.op == snappy_pkg::CMD_LIT;
	wire wr_cp   = v_s2 && oslot;
	// offset-one copy reads the slot that is being written this cycle
	wire rd_byp  = wr_cp && rd_ptr_q == wp_q;

	// History write: literal or copied byte; read one byte per cycle while stage 2 can drain
	always_ff @(posedge clk) begin
		if (wr_cp) hist_q[wp_q] <= rdat_s2;
		else if (wr_lit) hist_q[wp_q] <= cmd.lit;
		if (rd_go) rdat_s2 <= rd_byp ? rdat_s2 : hist_q[rd_ptr_q];
	end

	// Read after a pending write to the same slot must see that byte
	wire [snappy_pkg::HistAw-1:0] wp_n = wp_q + snappy_pkg::HistAw'(wr_cp || wr_lit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; busy_q <= 1'b0; left_q <= '0; rd_ptr_q <= '0; last_q <= 1'b0;
			v_s2 <= 1'b0; fin_s2 <= 1'b0; end_s2 <= 1'b0;
			ov_q <= 1'b0; rl_q <= 1'b0; err_q <= 1'b0; se_q <= 1'b0; db_q <= '0;
		end else begin
			// write pointer; the end of a stream restarts it at zero
			if ((take && cmd.last && cmd.op != snappy_pkg::CMD_COPY) || (wr_cp && end_s2))
				wp_q <= '0;
			else if (wr_cp || wr_lit)
				wp_q <= wp_n;
			if (rd_go) v_s2 <= 1'b1;
			else if (wr_cp) v_s2 <= 1'b0;
			// copy engine
			if (take && cmd.op == snappy_pkg::CMD_COPY) begin
				busy_q   <= 1'b1;
				left_q   <= cmd.len;
				rd_ptr_q <= wp_q - cmd.offset;
				last_q   <= cmd.last;
			end else if (rd_go) begin
				fin_s2   <= left_q == snappy_pkg::LenW'(1);
				end_s2   <= last_q && left_q == snappy_pkg::LenW'(1);
				rd_ptr_q <= rd_ptr_q + 1'b1;
				left_q   <= left_q - 1'b1;
				if (left_q == snappy_pkg::LenW'(1)) busy_q <= 1'b0;
			end
			// output register
			if (oslot) begin
				if (nxt_emits) begin
					ov_q <= 1'b1; db_q <= rdat_s2; rl_q <= fin_s2;
					err_q <= 1'b0; se_q <= end_s2;
				end else if (take && cmd.op == snappy_pkg::CMD_LIT) begin
					ov_q <= 1'b1; db_q <= cmd.lit; rl_q <= 1'b1;
					err_q <= 1'b0; se_q <= cmd.last;
				end else if (take && cmd.op == snappy_pkg::CMD_ERR) begin
					ov_q <= 1'b1; db_q <= '0; rl_q <= 1'b1;
					err_q <= 1'b1; se_q <= cmd.last;
				end else begin
					ov_q <= 1'b0;
				end
			end
		end
	end

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && err_q) |-> (db_q == '0 && rl_q))
		else $error("error result with data");
	a_one_src: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_cp && wr_lit))
		else $error("two history writers");
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !cmd_ready)
		else $error("request taken during copy");

endmodule

FILE: hw/rtl/snappy_block_decompressor.sv
// Snappy block decompressor top level: parser, request queue, executor.
// A literal byte passes the request queue and the output register before it is offered.
// Literals flow one byte per cycle while out_ready holds; a copy of n bytes holds
// the executor; one history read per cycle on the single read port unless out stalls.
// Reset (arst_n, async low) clears control state; history holds no reset value.
module snappy_block_decompressor (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       stream_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] data_byte,
	output logic       run_last,
	output logic       error_flag,
	output logic       stream_end
);

	snappy_pkg::cmd_t f_cmd, b_cmd;
	logic f_valid, f_ready, b_valid, b_ready;
	logic fifo_wr;

	snappy_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_byte, .stream_last,
		.cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
	);

	assign fifo_wr = f_valid && f_cmd.op != snappy_pkg::CMD_END;

	snappy_fifo u_fifo (
		.clk, .arst_n, .wr_valid(fifo_wr), .wr_ready(f_ready), .wr_data(f_cmd),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_cmd)
	);

	snappy_back u_back (
		.clk, .arst_n, .cmd_valid(b_valid), .cmd_ready(b_ready), .cmd(b_cmd),
		.out_valid, .out_ready, .data_byte, .run_last, .error_flag, .stream_end
	);

endmodule
